>>> hw/rtl/kbd_hid_pkg.sv
// shared constants, default key map and command type for the keyboard to hid report block
package kbd_hid_pkg;

	// report and key map geometry
	localparam int KEY_SLOTS    = 6;
	localparam int NUM_KEYCODES = 128;
	localparam int OUT_SLOTS    = 6;
	localparam int MAP_DEPTH    = 128;
	localparam int KEY_W        = 7;
	localparam int CODE_W       = 8;
	localparam int SLOT_ARR     = (KEY_SLOTS > OUT_SLOTS) ? KEY_SLOTS : OUT_SLOTS;
	localparam int SLOT_CNT_W   = $clog2(KEY_SLOTS + 1);

	localparam logic [KEY_W-1:0] SCAN_LAST = KEY_W'(NUM_KEYCODES - 1);

	// keyboard response bytes and hid codes
	localparam logic [7:0] RESP_RESET    = 8'hff;
	localparam logic [7:0] RESP_LAYOUT   = 8'hfe;
	localparam logic [7:0] POST_OK       = 8'h04;
	localparam logic [7:0] MOD_BASE      = 8'he0;
	localparam logic [7:0] MOD_LIMIT     = 8'he8;
	localparam logic [7:0] CODE_NONE     = 8'h00;
	localparam logic [7:0] CODE_ROLLOVER = 8'h01;

	// input item kinds
	localparam logic MODE_REMAP = 1'b1;

	// key number to hid usage code after reset
	localparam logic [CODE_W-1:0] DEFAULT_MAP [MAP_DEPTH] = '{
		8'h02, 8'h78, 8'h81, 8'h79, 8'h80, 8'h3a, 8'h3b, 8'h43,
		8'h3c, 8'h44, 8'h3d, 8'h45, 8'h3e, 8'he6, 8'h3f, 8'h00,
		8'h40, 8'h41, 8'h42, 8'he2, 8'h52, 8'h48, 8'h46, 8'h47,
		8'h50, 8'h00, 8'h7a, 8'h51, 8'h4f, 8'h29, 8'h1e, 8'h1f,
		8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h2d, 8'h2e, 8'h35, 8'h2a, 8'h49, 8'h7f, 8'h54, 8'h55,
		8'h66, 8'h00, 8'h63, 8'h7c, 8'h4a, 8'h2b, 8'h14, 8'h1a,
		8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c, 8'h12, 8'h13,
		8'h2f, 8'h30, 8'h4c, 8'h65, 8'h5f, 8'h60, 8'h61, 8'h56,
		8'h74, 8'h7d, 8'h4d, 8'h00, 8'he0, 8'h04, 8'h16, 8'h07,
		8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33, 8'h34,
		8'h31, 8'h28, 8'h58, 8'h5c, 8'h5d, 8'h5e, 8'h62, 8'h7e,
		8'h4b, 8'h7b, 8'h53, 8'he1, 8'h1d, 8'h1b, 8'h06, 8'h19,
		8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'he5, 8'h00,
		8'h59, 8'h5a, 8'h5b, 8'h00, 8'h00, 8'h00, 8'h75, 8'h39,
		8'he3, 8'h2c, 8'he7, 8'h4e, 8'h64, 8'h57, 8'h00, 8'h00
	};

	// decoded action of one accepted input transfer
	typedef struct packed {
		logic              key_we;
		logic [KEY_W-1:0]  key;
		logic              key_set;
		logic              map_we;
		logic [KEY_W-1:0]  map_idx;
		logic [CODE_W-1:0] map_code;
		logic              scan;
	} kbd_hid_cmd_t;

endpackage

>>> hw/rtl/kbd_hid_rx.sv
// receive state tracking and decode of input transfers into map updates
module kbd_hid_rx (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       mode,
	input  logic [7:0]                 kbd_byte,
	input  logic [6:0]                 remap_index,
	input  logic [7:0]                 remap_code,
	output kbd_hid_pkg::kbd_hid_cmd_t  cmd
);
	import kbd_hid_pkg::*;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_AFTER_RESET,
		RX_AFTER_LAYOUT
	} rx_state_t;

	rx_state_t       state_q;
	rx_state_t       state_d;
	logic [7:0]      eff_byte;
	kbd_hid_cmd_t    cmd_d;

	// make of key 0 stands for a failed self test
	assign eff_byte = (state_q == RX_AFTER_RESET) ? 8'h00 : kbd_byte;

	// decode the transfer against the receive state
	always_comb begin
		state_d          = state_q;
		cmd_d            = '0;
		cmd_d.key        = eff_byte[KEY_W-1:0];
		cmd_d.key_set    = ~eff_byte[7];
		cmd_d.map_idx    = remap_index;
		cmd_d.map_code   = remap_code;
		if (mode == MODE_REMAP) begin
			cmd_d.map_we = ({1'b0, remap_index} < (KEY_W+1)'(NUM_KEYCODES));
		end else if (state_q == RX_AFTER_LAYOUT) begin
			state_d = RX_IDLE;
		end else if (kbd_byte == RESP_RESET) begin
			state_d = RX_AFTER_RESET;
		end else if (kbd_byte == RESP_LAYOUT) begin
			state_d = RX_AFTER_LAYOUT;
		end else if (state_q == RX_AFTER_RESET && kbd_byte == POST_OK) begin
			state_d = RX_IDLE;
		end else begin
			state_d      = RX_IDLE;
			cmd_d.key_we = ({1'b0, cmd_d.key} < (KEY_W+1)'(NUM_KEYCODES));
			cmd_d.scan   = 1'b1;
		end
	end

	// command is only live on an accepted transfer
	always_comb begin
		cmd        = cmd_d;
		cmd.key_we = cmd_d.key_we & accept;
		cmd.map_we = cmd_d.map_we & accept;
		cmd.scan   = cmd_d.scan & accept;
	end

	// receive state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RX_IDLE;
		end else if (accept) begin
			case (state_d)
				RX_IDLE, RX_AFTER_RESET, RX_AFTER_LAYOUT: state_q <= state_d;
				default:                                  state_q <= RX_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/kbd_hid_scan.sv
// pressed map and remap memories, key scan sequencer and report output register
module kbd_hid_scan (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  kbd_hid_pkg::kbd_hid_cmd_t                    cmd,
	output logic                                         busy,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic [7:0]                                   modifier_mask,
	output logic [kbd_hid_pkg::OUT_SLOTS-1:0][7:0]       key_slots
);
	import kbd_hid_pkg::*;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_SCAN,
		SC_DRAIN,
		SC_HOLD
	} scan_state_t;

	scan_state_t                     state_q;
	logic [KEY_W-1:0]                idx_q;
	logic                            rd_en;

	logic [CODE_W-1:0]               map_mem [MAP_DEPTH];
	logic                            press_mem [MAP_DEPTH];
	logic [MAP_DEPTH-1:0]            map_vld_q;
	logic [MAP_DEPTH-1:0]            press_vld_q;

	logic                            rd_s1;
	logic [KEY_W-1:0]                idx_s1;
	logic [CODE_W-1:0]               code_s1;
	logic                            press_s1;
	logic                            map_vld_s1;
	logic                            press_vld_s1;

	logic [CODE_W-1:0]               held_code;
	logic                            held;

	logic [7:0]                      mods_q;
	logic [SLOT_CNT_W-1:0]           used_q;
	logic                            ovf_q;
	logic [SLOT_ARR-1:0][7:0]        slots_q;
	logic [OUT_SLOTS-1:0][7:0]       report_slots;

	assign rd_en = (state_q == SC_SCAN);
	assign busy  = (state_q != SC_IDLE);

	// memory writes and registered scan reads
	always_ff @(posedge clk) begin
		if (cmd.map_we) begin
			map_mem[cmd.map_idx] <= cmd.map_code;
		end
		if (cmd.key_we) begin
			press_mem[cmd.key] <= cmd.key_set;
		end
		if (rd_en) begin
			code_s1  <= map_mem[idx_q];
			press_s1 <= press_mem[idx_q];
			idx_s1   <= idx_q;
		end
	end

	// written flags: an unwritten entry reads as its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q    <= '0;
			press_vld_q  <= '0;
			map_vld_s1   <= 1'b0;
			press_vld_s1 <= 1'b0;
		end else begin
			if (cmd.map_we) begin
				map_vld_q[cmd.map_idx] <= 1'b1;
			end
			if (cmd.key_we) begin
				press_vld_q[cmd.key] <= 1'b1;
			end
			if (rd_en) begin
				map_vld_s1   <= map_vld_q[idx_q];
				press_vld_s1 <= press_vld_q[idx_q];
			end
		end
	end

	// code of the key read last cycle
	assign held_code = map_vld_s1 ? code_s1 : DEFAULT_MAP[idx_s1];
	assign held      = rd_s1 & press_vld_s1 & press_s1 & (held_code != CODE_NONE);

	// rollover fills every real slot
	always_comb begin
		for (int i = 0; i < OUT_SLOTS; i++) begin
			report_slots[i] = (ovf_q && i < KEY_SLOTS) ? CODE_ROLLOVER : slots_q[i];
		end
	end

	// scan sequencer, shared code classifier and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= SC_IDLE;
			idx_q         <= '0;
			rd_s1         <= 1'b0;
			mods_q        <= '0;
			used_q        <= '0;
			ovf_q         <= 1'b0;
			slots_q       <= '0;
			out_valid     <= 1'b0;
			modifier_mask <= '0;
			key_slots     <= '0;
		end else begin
			rd_s1 <= rd_en;
			// taken report leaves unless the hold state loads the next one
			if (out_valid && !out_stall && state_q != SC_HOLD) begin
				out_valid <= 1'b0;
			end

			// classify one held key per cycle
			if (held) begin
				if (held_code >= MOD_BASE) begin
					if (held_code < MOD_LIMIT) begin
						mods_q[held_code[2:0]] <= 1'b1;
					end
				end else if (used_q < SLOT_CNT_W'(KEY_SLOTS)) begin
					for (int i = 0; i < KEY_SLOTS; i++) begin
						if (used_q == SLOT_CNT_W'(i)) begin
							slots_q[i] <= held_code;
						end
					end
					used_q <= used_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end

			case (state_q)
				SC_IDLE: begin
					if (cmd.scan) begin
						idx_q   <= '0;
						mods_q  <= '0;
						used_q  <= '0;
						ovf_q   <= 1'b0;
						slots_q <= '0;
						state_q <= SC_SCAN;
					end
				end
				SC_SCAN: begin
					if (idx_q == SCAN_LAST) begin
						state_q <= SC_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				SC_DRAIN: begin
					state_q <= SC_HOLD;
				end
				SC_HOLD: begin
					if (!out_valid || !out_stall) begin
						out_valid     <= 1'b1;
						modifier_mask <= mods_q;
						key_slots     <= report_slots;
						state_q       <= SC_IDLE;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/keyboard_scancode_to_hid_report.sv
// top level: serial keyboard bytes in, usb hid boot reports out
//
// Input channel (in_valid / in_stall) carries one transfer per keyboard byte
// (mode 0) or per remap table write (mode 1). Output channel (out_valid /
// out_stall) carries one boot report: modifier mask and six key slots.
// Remap writes, the 0xff / 0xfe responses and swallowed bytes are taken
// without a stall and give no report. A make or break byte updates the
// pressed map and then scans all keys one per cycle through the remap
// memory read port, so such a byte keeps in_stall high through the scan,
// drain and hold states; no new byte is taken until its report has been
// loaded into the output register.
// The output register holds a finished report while out_stall is high; a new
// byte is still taken then, and its report waits in the scan stage until the
// register is free.
// Reset clears the receive state, the output register and the written flags
// of both memories: the pressed map reads as all released and the remap
// table as its default map at once, with no clearing pass.
module keyboard_scancode_to_hid_report (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] kbd_byte,
	input  logic [6:0] remap_index,
	input  logic [7:0] remap_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] modifier_mask,
	output logic [7:0] key_slot0,
	output logic [7:0] key_slot1,
	output logic [7:0] key_slot2,
	output logic [7:0] key_slot3,
	output logic [7:0] key_slot4,
	output logic [7:0] key_slot5
);
	import kbd_hid_pkg::*;

	logic                      busy;
	logic                      in_accept;
	kbd_hid_cmd_t              cmd;
	logic [OUT_SLOTS-1:0][7:0] key_slots;

	// one item at a time while a scan runs
	assign in_stall  = busy;
	assign in_accept = in_valid & ~in_stall;

	// receive state and decode
	kbd_hid_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.mode        (mode),
		.kbd_byte    (kbd_byte),
		.remap_index (remap_index),
		.remap_code  (remap_code),
		.cmd         (cmd)
	);

	// map storage, scan and report register
	kbd_hid_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.modifier_mask (modifier_mask),
		.key_slots     (key_slots)
	);

	assign key_slot0 = key_slots[0];
	assign key_slot1 = key_slots[1];
	assign key_slot2 = key_slots[2];
	assign key_slot3 = key_slots[3];
	assign key_slot4 = key_slots[4];
	assign key_slot5 = key_slots[5];

	// a report never follows an input transfer in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !$rose(out_valid))
		else $error("report appeared right after an input transfer");

	// a new report only comes out of a running scan
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("report without a scan");

	// modifier codes never land in a key slot
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_slot0 < MOD_BASE) && (key_slot1 < MOD_BASE) &&
			(key_slot2 < MOD_BASE) && (key_slot3 < MOD_BASE) &&
			(key_slot4 < MOD_BASE) && (key_slot5 < MOD_BASE))
		else $error("modifier code in key slot");

endmodule

>>> verif/tb_keyboard_scancode_to_hid_report.sv
// testbench for keyboard_scancode_to_hid_report: byte streams checked against a boot report predictor
`timescale 1ns / 100ps

module tb_keyboard_scancode_to_hid_report;
	import kbd_hid_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int SCAN_CYCLES  = NUM_KEYCODES + 3;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int HOLD_CYCLES  = 900;
	localparam logic MODE_KEY   = 1'b0;

	typedef enum logic [1:0] {
		RX_IDLE         = 2'd0,
		RX_AFTER_RESET  = 2'd1,
		RX_AFTER_LAYOUT = 2'd2
	} rx_state_t;

	typedef struct packed {
		logic [7:0]                mods;
		logic [OUT_SLOTS-1:0][7:0] slots;
	} hid_report_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       mode        = 1'b0;
	logic [7:0] kbd_byte    = 8'h00;
	logic [6:0] remap_index = 7'h00;
	logic [7:0] remap_code  = 8'h00;
	logic       out_stall   = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] modifier_mask;
	logic [7:0] key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5;

	keyboard_scancode_to_hid_report dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predictor state: held keys, key to hid code table, receive tracking
	logic [NUM_KEYCODES-1:0] held_keys;
	logic [CODE_W-1:0]       hid_codes [MAP_DEPTH];
	rx_state_t               rx_state;
	hid_report_t             pending_reports [$];

	int errors          = 0;
	int items_sent      = 0;
	int reports_seen    = 0;
	int remaps_sent     = 0;
	int rollover_count  = 0;
	int cycle_count     = 0;
	int hold_request    = 0;
	int stall_left      = 0;
	int target_held     = 4;
	bit tx_bursts       = 1'b1;
	bit rx_bursts       = 1'b1;

	function automatic void model_reset();
		held_keys = '0;
		for (int k = 0; k < MAP_DEPTH; k++)
			hid_codes[k] = DEFAULT_MAP[k];
		rx_state = RX_IDLE;
	endfunction

	// scan held keys in order: modifiers to the mask, others to slots
	function automatic hid_report_t predict_report();
		hid_report_t r;
		int          used;
		bit          overflow;
		logic [7:0]  c;
		r        = '0;
		used     = 0;
		overflow = 1'b0;
		for (int k = 0; k < NUM_KEYCODES; k++) begin
			c = hid_codes[k];
			if (held_keys[k] && c >= MOD_BASE) begin
				if (c < MOD_LIMIT)
					r.mods[c[2:0]] = 1'b1;
			end else if (held_keys[k] && c != CODE_NONE) begin
				if (used < KEY_SLOTS) begin
					r.slots[used] = c;
					used++;
				end else begin
					overflow = 1'b1;
				end
			end
		end
		if (overflow) begin
			rollover_count++;
			for (int i = 0; i < KEY_SLOTS; i++)
				r.slots[i] = CODE_ROLLOVER;
		end
		return r;
	endfunction

	// update predictor state for one accepted transfer
	function automatic void apply_item(input logic m, input logic [7:0] b,
			input logic [6:0] idx, input logic [7:0] code);
		logic [7:0] key_byte;
		key_byte = b;
		if (m == MODE_REMAP) begin
			hid_codes[idx] = code;
			remaps_sent++;
		end else if (rx_state == RX_AFTER_LAYOUT) begin
			rx_state = RX_IDLE;
		end else if (b == RESP_RESET) begin
			rx_state = RX_AFTER_RESET;
		end else if (b == RESP_LAYOUT) begin
			rx_state = RX_AFTER_LAYOUT;
		end else if (rx_state == RX_AFTER_RESET && b == POST_OK) begin
			rx_state = RX_IDLE;
		end else begin
			// any other byte after a reset response reads as a make of key 0
			if (rx_state == RX_AFTER_RESET)
				key_byte = 8'h00;
			rx_state = RX_IDLE;
			held_keys[key_byte[6:0]] = ~key_byte[7];
			pending_reports.push_back(predict_report());
		end
	endfunction

	// one input transfer, with an optional idle burst before it
	task automatic send_item(input logic m, input logic [7:0] b,
			input logic [6:0] idx, input logic [7:0] code);
		if (tx_bursts && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			do begin
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end while ($urandom_range(0, 2) == 0);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		kbd_byte    <= b;
		remap_index <= idx;
		remap_code  <= code;
		do @(posedge clk); while (in_stall);
		items_sent++;
		apply_item(m, b, idx, code);
	endtask

	task automatic send_key(input logic [7:0] b);
		send_item(MODE_KEY, b, 7'($urandom), 8'($urandom));
	endtask

	task automatic send_remap(input logic [6:0] idx, input logic [7:0] code);
		send_item(MODE_REMAP, 8'($urandom), idx, code);
	endtask

	// stop offering and wait for every predicted report
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	function automatic logic [7:0] random_code();
		case ($urandom_range(0, 3))
			0, 1: return 8'($urandom_range(4, 8'h65));
			2: return MOD_BASE + 8'($urandom_range(0, 7));
			default: return 8'($urandom);
		endcase
	endfunction

	// key number extremes, modifiers and a break
	task automatic test_key_extremes();
		send_key(8'h00);
		send_key(8'h7f);
		send_key(8'h4c);
		send_key(8'h7a);
		send_key(8'h80);
		wait_drain();
	endtask

	// reset and layout responses and the bytes that follow them
	task automatic test_receive_states();
		send_key(RESP_RESET);
		send_key(POST_OK);
		send_key(RESP_RESET);
		send_key(8'h85);
		send_key(RESP_LAYOUT);
		send_key(RESP_RESET);
		send_key(RESP_RESET);
		send_key(RESP_RESET);
		send_key(POST_OK);
		send_key(RESP_RESET);
		send_key(RESP_LAYOUT);
		send_key(8'h20);
		wait_drain();
	endtask

	// table writes at the index and code extremes, plus modifier and ignored codes
	task automatic test_remap_writes();
		send_remap(7'h7f, 8'hff);
		send_remap(7'h00, 8'h00);
		send_remap(7'h05, 8'he4);
		send_key(8'h05);
		send_remap(7'h08, MOD_LIMIT);
		send_key(8'h08);
		wait_drain();
	endtask

	// seven ordinary keys held at once
	task automatic test_rollover();
		for (int k = 30; k < 37; k++)
			send_key(8'(k));
		wait_drain();
	endtask

	// mostly plausible make / break traffic, some responses, table writes and noise
	task automatic send_random();
		int         pick;
		logic [6:0] key;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 31) == 0)
			target_held = $urandom_range(0, 10);
		if (pick < 6) begin
			send_remap(7'($urandom), random_code());
		end else if (pick < 9) begin
			send_key(RESP_RESET);
			send_key($urandom_range(0, 1) ? POST_OK : 8'($urandom));
		end else if (pick < 11) begin
			send_key(RESP_LAYOUT);
			send_key(8'($urandom));
		end else if (pick < 14) begin
			send_key(8'($urandom));
		end else if ($countones(held_keys[125:0]) < target_held || held_keys[125:0] == '0) begin
			send_key({1'b0, 7'($urandom_range(0, 125))});
		end else begin
			key = 7'($urandom_range(0, 125));
			while (!held_keys[key])
				key = (key == 7'd125) ? 7'd0 : key + 7'd1;
			send_key({1'b1, key});
		end
	endtask

	task automatic test_random_traffic(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_random();
		wait_drain();
	endtask

	// receiver holds off while bytes keep coming, so the block backs up
	task automatic test_output_hold();
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 8; i++)
			send_key({1'b0, 7'($urandom_range(0, 125))});
		wait_drain();
	endtask

	// receiver stall: long hold on request, else random bursts
	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left   = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_bursts && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each report transfer with the oldest prediction
	always @(posedge clk) begin : check_reports
		hid_report_t got;
		hid_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.mods  = modifier_mask;
			got.slots = {key_slot5, key_slot4, key_slot3, key_slot2, key_slot1, key_slot0};
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: report with none expected, expected nothing actual %h", $time, got);
			end else begin
				want = pending_reports.pop_front();
				reports_seen++;
				if (got.mods !== want.mods) begin
					errors++;
					$display("%0t: modifier_mask expected %02h actual %02h",
						$time, want.mods, got.mods);
				end
				for (int i = 0; i < OUT_SLOTS; i++)
					if (got.slots[i] !== want.slots[i]) begin
						errors++;
						$display("%0t: key_slot%0d expected %02h actual %02h",
							$time, i, want.slots[i], got.slots[i]);
					end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d reports still expected", $time, pending_reports.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		model_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_key_extremes();
		test_receive_states();
		test_remap_writes();
		test_rollover();
		test_random_traffic(900);
		test_output_hold();
		test_random_traffic(700);
		// last stretch with both sides always ready
		tx_bursts = 1'b0;
		rx_bursts = 1'b0;
		test_random_traffic(200);

		wait_drain();
		repeat (SCAN_CYCLES + 8) @(posedge clk);
		if (pending_reports.size() != 0) begin
			errors += pending_reports.size();
			$display("%0t: %0d reports never arrived", $time, pending_reports.size());
		end

		$display("sent %0d transfers (%0d table writes), checked %0d reports, %0d in rollover",
			items_sent, remaps_sent, reports_seen, rollover_count);
		$display("includes response sequences, a long receiver hold and a gap-free stretch");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
